// ===== rtl/msc_pkg.sv =====
// Package for the minimum square-sum counter: widths, step codes, control and status types.
// Holds the microprogram that the sequencer steps through. Depends on nothing.
package msc_pkg;

    localparam int TARGET_W = 12;
    localparam int COUNT_W = 3;
    localparam int MAX_TARGET_DEF = 4095;
    localparam int STEP_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd7;
    localparam logic [COUNT_W-1:0] OUT_OF_RANGE = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd4;

    localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_VINIT = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SCAN = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WRITE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DELIVER = 3'd5;

    typedef enum logic [1:0] {
        HOLD_NEVER = 2'd0,
        HOLD_NO_INPUT = 2'd1,
        HOLD_OUT_BUSY = 2'd2
    } t_hold;

    typedef enum logic [2:0] {
        JMP_NEVER = 3'd0,
        JMP_ALWAYS = 3'd1,
        JMP_SHORT = 3'd2,
        JMP_MORE_SQ = 3'd3,
        JMP_MORE_V = 3'd4
    } t_jump;

    typedef struct packed {
        logic              in_ready;
        logic              init_v;
        logic              init_j;
        logic              scan;
        logic              write_v;
        logic              out_load;
        t_hold             hold;
        t_jump             jump;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic short_path;
        logic more_sq;
        logic more_v;
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        in_ready: 1'b0, init_v: 1'b0, init_j: 1'b0, scan: 1'b0, write_v: 1'b0,
        out_load: 1'b0, hold: HOLD_NEVER, jump: JMP_ALWAYS, target: STEP_WAIT
    };

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = CTRL_NOP;
        unique case (step)
            STEP_WAIT: begin
                c.in_ready = 1'b1;
                c.hold = HOLD_NO_INPUT;
                c.jump = JMP_NEVER;
            end
            STEP_CHECK: begin
                c.init_v = 1'b1;
                c.jump = JMP_SHORT;
                c.target = STEP_DELIVER;
            end
            STEP_VINIT: begin
                c.init_j = 1'b1;
                c.jump = JMP_NEVER;
            end
            STEP_SCAN: begin
                c.scan = 1'b1;
                c.jump = JMP_MORE_SQ;
                c.target = STEP_SCAN;
            end
            STEP_WRITE: begin
                c.write_v = 1'b1;
                c.jump = JMP_MORE_V;
                c.target = STEP_VINIT;
            end
            STEP_DELIVER: begin
                c.out_load = 1'b1;
                c.hold = HOLD_OUT_BUSY;
                c.jump = JMP_ALWAYS;
                c.target = STEP_WAIT;
            end
            default: begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/msc_target_if.sv =====
// Input channel of the minimum square-sum counter: valid, ready and the target value.
// Depends on msc_pkg for the field width.
interface msc_target_if;
    logic                          valid;
    logic                          ready;
    logic [msc_pkg::TARGET_W-1:0]  target;

    modport source (output valid, output target, input ready);
    modport sink (input valid, input target, output ready);
endinterface

// ===== rtl/msc_count_if.sv =====
// Output channel of the minimum square-sum counter: valid, ready and the square count.
// Depends on msc_pkg for the field width.
interface msc_count_if;
    logic                         valid;
    logic                         ready;
    logic [msc_pkg::COUNT_W-1:0]  square_count;

    modport source (output valid, output square_count, input ready);
    modport sink (input valid, input square_count, output ready);
endinterface

// ===== rtl/msc_sequencer.sv =====
// Step counter and microprogram lookup of the minimum square-sum counter.
// Depends on msc_pkg for the control word, the status word and the microprogram.
module msc_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  msc_pkg::t_stat i_stat,
    output msc_pkg::t_ctrl o_ctrl
);
    import msc_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_hold;
    logic              w_jump;

    assign w_ctrl = ucode(r_step);
    assign o_ctrl = w_ctrl;

    always_comb begin
        unique case (w_ctrl.hold)
            HOLD_NEVER:    w_hold = 1'b0;
            HOLD_NO_INPUT: w_hold = !i_stat.in_valid;
            HOLD_OUT_BUSY: w_hold = i_stat.out_busy;
            default:       w_hold = 1'b0;
        endcase
        unique case (w_ctrl.jump)
            JMP_NEVER:   w_jump = 1'b0;
            JMP_ALWAYS:  w_jump = 1'b1;
            JMP_SHORT:   w_jump = i_stat.short_path;
            JMP_MORE_SQ: w_jump = i_stat.more_sq;
            JMP_MORE_V:  w_jump = i_stat.more_v;
            default:     w_jump = 1'b1;
        endcase
        priority if (w_hold) begin
            n_step = r_step;
        end else if (w_jump) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

`ifndef SYNTH
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.in_ready && i_stat.in_valid) |=> (r_step == STEP_CHECK))
        else $error("accepted item did not advance to the check step");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_DELIVER)
        else $error("step counter left the microprogram");
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_SCAN && !i_stat.more_sq) |=> (r_step == STEP_WRITE))
        else $error("scan loop did not end in the write step");
`endif

endmodule

// ===== rtl/msc_datapath.sv =====
// Datapath of the minimum square-sum counter: value and square registers, count table,
// minimum fold and output register. Depends on msc_pkg for types and constants.
module msc_datapath #(
    parameter int MAX_TARGET = msc_pkg::MAX_TARGET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msc_pkg::t_ctrl                i_ctrl,
    input  logic                          i_in_valid,
    input  logic [msc_pkg::TARGET_W-1:0]  i_target,
    input  logic                          i_out_ready,
    output msc_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [msc_pkg::COUNT_W-1:0]   o_out_count
);
    import msc_pkg::*;

    localparam int AW = (MAX_TARGET < 2) ? 1 : $clog2(MAX_TARGET + 1);
    localparam int DEPTH = MAX_TARGET + 1;

    logic [COUNT_W-1:0] r_table [DEPTH];
    logic [COUNT_W-1:0] r_rd;
    logic [AW-1:0]      r_n;
    logic               r_err;
    logic               r_zero;
    logic [AW-1:0]      r_v;
    logic [AW:0]        r_j;
    logic [AW+1:0]      r_sq;
    logic [COUNT_W-1:0] r_best;
    logic               r_pend;
    logic [COUNT_W-1:0] r_res;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_accept;
    logic [AW+1:0]      w_sq_next;
    logic [AW+1:0]      w_diff;
    logic [COUNT_W:0]   w_cand;
    logic [COUNT_W-1:0] w_fold;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;

    assign w_accept = i_ctrl.in_ready && i_in_valid;
    assign w_sq_next = r_sq + {r_j, 1'b1};
    assign w_diff = {2'b00, r_v} - r_sq;
    assign w_cand = {1'b0, r_rd} + 1'b1;
    assign w_fold = (r_pend && (w_cand < {1'b0, r_best})) ? w_cand[COUNT_W-1:0] : r_best;
    assign w_wr_en = i_ctrl.init_v || i_ctrl.write_v;
    assign w_wr_addr = i_ctrl.write_v ? r_v : '0;

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_stat.short_path = r_err || r_zero;
    assign o_stat.more_sq = w_sq_next <= {2'b00, r_v};
    assign o_stat.more_v = r_v != r_n;
    assign o_out_valid = r_out_valid;
    assign o_out_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[w_wr_addr] <= i_ctrl.write_v ? w_fold : '0;
        end
        if (i_ctrl.scan) begin
            r_rd <= r_table[w_diff[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n <= AW'(i_target);
            r_err <= int'(i_target) > MAX_TARGET;
            r_zero <= i_target == '0;
        end
        if (i_ctrl.init_v) begin
            r_v <= AW'(1);
            r_res <= r_err ? OUT_OF_RANGE : '0;
        end
        if (i_ctrl.init_j) begin
            r_j <= (AW + 1)'(1);
            r_sq <= (AW + 2)'(1);
            r_best <= COUNT_NONE;
        end
        if (i_ctrl.scan) begin
            r_best <= w_fold;
            r_j <= r_j + 1'b1;
            r_sq <= w_sq_next;
        end
        if (i_ctrl.write_v) begin
            r_res <= w_fold;
            r_v <= r_v + 1'b1;
        end
        if (i_ctrl.out_load && !o_stat.out_busy) begin
            r_out_count <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.init_j) begin
                r_pend <= 1'b0;
            end else if (i_ctrl.scan) begin
                r_pend <= 1'b1;
            end
            if (i_ctrl.out_load && !o_stat.out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.write_v |-> (r_pend && w_fold <= COUNT_MAX))
        else $error("table entry written without a folded candidate or above four");
    a_square_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan |-> (r_sq != '0 && r_sq <= {2'b00, r_v}))
        else $error("square offset beyond the current value");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_count)))
        else $error("waiting result changed before it was taken");
`endif

endmodule

// ===== rtl/min_square_sum_count.sv =====
// Minimum square-sum counter: for each target n, the fewest perfect squares that sum to n.
// Input channel msc_target_if (target), output channel msc_count_if (square_count).
// An item is accepted when valid and ready are high at a rising edge of i_clk.
// The block works on one item at a time; ready is high only while the sequencer waits.
// The count table is rebuilt for each item: each value v takes a setup step,
// one table read per square in the scan loop, and a write step.
// A target of zero, or one above MAX_TARGET (answered with 7), goes from the check step straight to delivery.
// The sequencer returns to its wait step after delivery, and only there is the next item accepted.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, the sequencer holds its final step until the register
// is free, and the waiting result stays unchanged.
// Reset (i_rst_n low at a rising edge) empties the output register and returns the
// sequencer to its wait step; the table needs no clearing, as every entry is written
// before it is read within an item.
module min_square_sum_count #(
    parameter int MAX_TARGET = msc_pkg::MAX_TARGET_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msc_target_if.sink    i_target_if,
    msc_count_if.source   o_count_if
);
    import msc_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    assign i_target_if.ready = w_ctrl.in_ready;

    msc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    msc_datapath #(
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in_valid  (i_target_if.valid),
        .i_target    (i_target_if.target),
        .i_out_ready (o_count_if.ready),
        .o_stat      (w_stat),
        .o_out_valid (o_count_if.valid),
        .o_out_count (o_count_if.square_count)
    );

endmodule

// ===== tb/min_square_sum_count_tb.sv =====
// Testbench for min_square_sum_count: a table of directed targets, then random targets
// checked against a dynamic-program predictor. Uses msc_pkg and the RTL channel interfaces.
`timescale 1ns / 100ps

module min_square_sum_count_tb;
    import msc_pkg::*;

    localparam int ITEMS_PER_PHASE = 25;
    localparam int PHASE_COUNT = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int DIRECTED_ROWS = 22;

    typedef struct {
        logic [TARGET_W-1:0] target;
        bit                  known;
        logic [COUNT_W-1:0]  count;
    } t_target_row;

    logic i_clk;
    logic i_rst_n;

    msc_target_if target_ch ();
    msc_count_if  count_ch ();

    min_square_sum_count DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_target_if (target_ch),
        .o_count_if  (count_ch)
    );

    logic [COUNT_W-1:0] expected_counts [$];
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;

    t_target_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{12'd0,    1'b1, 3'd0},
        '{12'd1,    1'b1, 3'd1},
        '{12'd2,    1'b1, 3'd2},
        '{12'd3,    1'b1, 3'd3},
        '{12'd4,    1'b1, 3'd1},
        '{12'd7,    1'b1, 3'd4},
        '{12'd12,   1'b1, 3'd3},
        '{12'd13,   1'b1, 3'd2},
        '{12'd15,   1'b1, 3'd4},
        '{12'd16,   1'b1, 3'd1},
        '{12'd4095, 1'b1, 3'd4},
        '{12'd0,    1'b1, 3'd0},
        '{12'd5,    1'b0, 3'd0},
        '{12'd6,    1'b0, 3'd0},
        '{12'd8,    1'b0, 3'd0},
        '{12'd11,   1'b0, 3'd0},
        '{12'd28,   1'b0, 3'd0},
        '{12'd48,   1'b0, 3'd0},
        '{12'd127,  1'b0, 3'd0},
        '{12'd255,  1'b0, 3'd0},
        '{12'd1024, 1'b1, 3'd1},
        '{12'd2048, 1'b1, 3'd2}
    };

    function automatic logic [COUNT_W-1:0] fewest_squares(input logic [TARGET_W-1:0] t);
        logic [COUNT_W-1:0] counts [0:MAX_TARGET_DEF];
        logic [COUNT_W:0]   best;
        logic [COUNT_W:0]   trial;
        int                 v;
        int                 k;
        if (int'(t) > MAX_TARGET_DEF) begin
            return OUT_OF_RANGE;
        end
        counts[0] = '0;
        for (v = 1; v <= int'(t); v++) begin
            best = {1'b0, COUNT_NONE};
            for (k = 1; k * k <= v; k++) begin
                trial = {1'b0, counts[v - k * k]} + 1'b1;
                if (trial < best) begin
                    best = trial;
                end
            end
            counts[v] = best[COUNT_W-1:0];
        end
        return counts[t];
    endfunction

    // Most targets stay small because the block's work per item grows faster than linearly with n.
    function automatic logic [TARGET_W-1:0] pick_target();
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            return TARGET_W'($urandom_range(4095));
        end else if (r < 13) begin
            return TARGET_W'($urandom_range(1023));
        end else if (r < 30) begin
            return TARGET_W'($urandom_range(15));
        end else begin
            return TARGET_W'($urandom_range(255));
        end
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic send_target(input logic [TARGET_W-1:0] t, input bit known,
                               input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < idle_pct) begin
            target_ch.valid <= 1'b0;
            target_ch.target <= TARGET_W'($urandom);
            @(posedge i_clk);
        end
        target_ch.valid <= 1'b1;
        target_ch.target <= t;
        do @(posedge i_clk); while (!(target_ch.valid && target_ch.ready));
        expected_counts.push_back(known ? count : fewest_squares(t));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        count_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            count_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : count_check
        logic [COUNT_W-1:0] want;
        if (i_rst_n && count_ch.valid && count_ch.ready) begin
            if (expected_counts.size() == 0) begin
                flag_error($sformatf("unexpected square_count %0d", count_ch.square_count));
            end else begin
                want = expected_counts.pop_front();
                if (count_ch.square_count !== want) begin
                    flag_error($sformatf("square_count expected %0d, got %0d",
                                         want, count_ch.square_count));
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("min_square_sum_count verification failed");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int n;
        i_rst_n <= 1'b0;
        target_ch.valid <= 1'b0;
        target_ch.target <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_target(directed_rows[i].target, directed_rows[i].known,
                        directed_rows[i].count);
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            unique case (p)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 68;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 68;
                end
                default: begin
                    idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_target(pick_target(), 1'b0, '0);
            end
        end
        target_ch.valid <= 1'b0;

        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("min_square_sum_count verification clean");
        end else begin
            $display("min_square_sum_count verification failed");
        end
        $finish;
    end

endmodule
